// ===== sv/rrs_pkg.sv =====
package rrs_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam logic [31:0] TIME_SLICE_RESET = 32'd10000;

   localparam logic [1:0] FUNC_SELECT = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_CLAIM  = 2'd2;

   localparam logic [1:0] STAT_DEAD  = 2'd0;
   localparam logic [1:0] STAT_READY = 2'd1;
   localparam logic [1:0] STAT_SLEEP = 2'd2;
   localparam logic [1:0] STAT_WAIT  = 2'd3;

   localparam logic [1:0] REASON_READY   = 2'd0;
   localparam logic [1:0] REASON_SLEPT   = 2'd1;
   localparam logic [1:0] REASON_EXITED  = 2'd2;
   localparam logic [1:0] REASON_TIMEOUT = 2'd3;

   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
   localparam logic [2:0] ERR_FULL     = 3'd2;
   localparam logic [2:0] ERR_PENDING  = 3'd3;
   localparam logic [2:0] ERR_DEADLOCK = 3'd4;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] wake_time;
      logic [3:0]  target;
      logic        target_valid;
      logic [31:0] ret_code;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== sv/round_robin_slot_scheduler_unit.sv =====
// A write item, or an item with an unused function code, gives its result in the next cycle.
// Select and claim items walk the task table RAM one entry per cycle; a waiter whose
// target entry is looked up also passes through the S_TGT state before the walk moves on.
// The next item is taken in the cycle its predecessor's result is shown; results cannot stall.
// Synchronous reset marks every entry dead through per-entry valid bits, sets the current
// slot to SLOTS-1, the claim pointer to 0 and the time slice to 10000.
module round_robin_slot_scheduler_unit #(
   parameter int SLOTS = rrs_pkg::SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [3:0]         req_slot,
   input  logic [63:0]        req_now,
   input  logic [1:0]         req_new_status,
   input  logic [63:0]        req_wake_time,
   input  logic [3:0]         req_target_slot,
   input  logic               req_target_valid,
   input  logic signed [31:0] req_exit_value,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic [3:0]         rsp_chosen_slot,
   output logic [1:0]         rsp_wake_reason,
   output logic signed [31:0] rsp_returned_code,
   output logic [2:0]         rsp_error,
   output logic [63:0]        rsp_slice_end,
   input  logic               csr_write_en,
   input  logic [31:0]        csr_write_data
);

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_TGT  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [IW-1:0]       cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic                claim_ff, claim_in;
   logic [63:0]         now_ff, now_in;
   rrs_pkg::entry_type  hold_ff, hold_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [IW-1:0]       cptr_ff, cptr_in;
   logic [31:0]         tslice_ff;
   logic [SLOTS-1:0]    valid_ff;
   logic                rv_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [3:0]          rsp_chosen_ff, rsp_chosen_in;
   logic [1:0]          rsp_reason_ff, rsp_reason_in;
   logic [31:0]         rsp_code_ff, rsp_code_in;
   logic [2:0]          rsp_error_ff, rsp_error_in;
   logic [63:0]         rsp_slice_ff, rsp_slice_in;

   logic [IW-1:0]       raddr, waddr;
   logic                we;
   rrs_pkg::entry_type  wdata, e, wr_e;
   logic [rrs_pkg::ENTRY_W-1:0] ram_rdata;
   logic [IW-1:0]       nxt_idx, first_idx;

   rrs_ram #(
      .WIDTH(rrs_pkg::ENTRY_W),
      .DEPTH(SLOTS)
   ) u_table (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(ram_rdata)
   );

   assign e = rv_ff ? rrs_pkg::entry_type'(ram_rdata) : '0;
   assign nxt_idx = (idx_ff == LAST) ? '0 : idx_ff + 1'b1;

   always_comb begin
      logic take, go_tgt, scan, pend_now;
      logic [1:0]  reason;
      logic [31:0] code;
      logic [2:0]  err;
      take     = 1'b0;
      go_tgt   = 1'b0;
      scan     = 1'b0;
      pend_now = 1'b0;
      reason   = rrs_pkg::REASON_READY;
      code     = '0;
      err      = rrs_pkg::ERR_OK;

      if (req_func == rrs_pkg::FUNC_CLAIM) begin
         first_idx = cptr_ff;
      end else begin
         first_idx = (cur_ff == LAST) ? '0 : cur_ff + 1'b1;
      end

      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      claim_in = claim_ff;
      now_in   = now_ff;
      hold_in  = hold_ff;
      cur_in   = cur_ff;
      cptr_in  = cptr_ff;
      raddr    = nxt_idx;
      we       = 1'b0;
      waddr    = idx_ff;
      wdata    = e;
      wr_e     = e;

      rsp_valid_in  = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_chosen_in = '0;
      rsp_reason_in = rrs_pkg::REASON_READY;
      rsp_code_in   = '0;
      rsp_error_in  = rrs_pkg::ERR_OK;
      rsp_slice_in  = '0;

      case (state_ff)
         S_IDLE: begin
            raddr = first_idx;
            if (start) begin
               case (req_func)
                  rrs_pkg::FUNC_SELECT, rrs_pkg::FUNC_CLAIM: begin
                     state_in = S_EVAL;
                     idx_in   = first_idx;
                     cnt_in   = '0;
                     pend_in  = 1'b0;
                     now_in   = req_now;
                     claim_in = (req_func == rrs_pkg::FUNC_CLAIM);
                  end
                  rrs_pkg::FUNC_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (32'(req_slot) < SLOTS) begin
                        we                 = 1'b1;
                        waddr              = IW'(req_slot);
                        wdata.status       = req_new_status;
                        wdata.wake_time    = req_wake_time;
                        wdata.target       = req_target_slot;
                        wdata.target_valid = req_target_valid;
                        wdata.ret_code     = req_exit_value;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_EVAL: begin
            scan    = 1'b1;
            hold_in = e;
            wr_e    = e;
            if (claim_ff) begin
               take = (e.status == rrs_pkg::STAT_DEAD);
            end else begin
               case (e.status)
                  rrs_pkg::STAT_READY: begin
                     take = 1'b1;
                  end
                  rrs_pkg::STAT_SLEEP: begin
                     if (e.wake_time < now_ff) begin
                        take   = 1'b1;
                        reason = rrs_pkg::REASON_SLEPT;
                     end else begin
                        pend_now = 1'b1;
                     end
                  end
                  rrs_pkg::STAT_WAIT: begin
                     if (e.target_valid && (32'(e.target) < SLOTS)) begin
                        go_tgt = 1'b1;
                     end else if (e.wake_time != '0) begin
                        if (e.wake_time < now_ff) begin
                           take   = 1'b1;
                           reason = rrs_pkg::REASON_TIMEOUT;
                           err    = rrs_pkg::ERR_TIMEOUT;
                        end else begin
                           pend_now = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (go_tgt) begin
               raddr    = IW'(e.target);
               state_in = S_TGT;
            end
         end
         S_TGT: begin
            scan = 1'b1;
            wr_e = hold_ff;
            if (e.status == rrs_pkg::STAT_DEAD) begin
               take   = 1'b1;
               reason = rrs_pkg::REASON_EXITED;
               code   = e.ret_code;
            end else if (hold_ff.wake_time != '0) begin
               if (hold_ff.wake_time < now_ff) begin
                  take   = 1'b1;
                  reason = rrs_pkg::REASON_TIMEOUT;
                  err    = rrs_pkg::ERR_TIMEOUT;
               end else begin
                  pend_now = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (scan) begin
         pend_in = pend_ff | pend_now;
      end
      wr_e.status = rrs_pkg::STAT_READY;
      if (claim_ff) begin
         wr_e.wake_time = '0;
      end

      if (scan && take) begin
         we            = 1'b1;
         waddr         = idx_ff;
         wdata         = wr_e;
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_found_in  = 1'b1;
         rsp_chosen_in = 4'(idx_ff);
         if (claim_ff) begin
            cptr_in = nxt_idx;
         end else begin
            cur_in        = idx_ff;
            rsp_reason_in = reason;
            rsp_code_in   = code;
            rsp_error_in  = err;
            rsp_slice_in  = now_ff + 64'(tslice_ff);
         end
      end else if (scan && !go_tgt) begin
         if (cnt_ff == LAST) begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (claim_ff) begin
               rsp_error_in = rrs_pkg::ERR_FULL;
            end else if (pend_ff || pend_now) begin
               rsp_error_in = rrs_pkg::ERR_PENDING;
            end else begin
               rsp_error_in = rrs_pkg::ERR_DEADLOCK;
            end
         end else begin
            idx_in   = nxt_idx;
            cnt_in   = cnt_ff + 1'b1;
            raddr    = nxt_idx;
            state_in = S_EVAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         claim_ff     <= 1'b0;
         cur_ff       <= LAST;
         cptr_ff      <= '0;
         tslice_ff    <= rrs_pkg::TIME_SLICE_RESET;
         valid_ff     <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         claim_ff     <= claim_in;
         cur_ff       <= cur_in;
         cptr_ff      <= cptr_in;
         if (csr_write_en) begin
            tslice_ff <= csr_write_data;
         end
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rv_ff        <= valid_ff[raddr];
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      hold_ff       <= hold_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_reason_ff <= rsp_reason_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_error_ff  <= rsp_error_in;
      rsp_slice_ff  <= rsp_slice_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_chosen_slot   = rsp_chosen_ff;
   assign rsp_wake_reason   = rsp_reason_ff;
   assign rsp_returned_code = rsp_code_ff;
   assign rsp_error         = rsp_error_ff;
   assign rsp_slice_end     = rsp_slice_ff;

   a_scan_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == rrs_pkg::FUNC_SELECT ||
                          req_func == rrs_pkg::FUNC_CLAIM)) |=> busy)
      else $error("select or claim item did not start a scan");

   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func != rrs_pkg::FUNC_SELECT &&
       req_func != rrs_pkg::FUNC_CLAIM) |=> (rsp_valid && !rsp_found && !busy))
      else $error("write item did not answer in one cycle");

   a_result_ends_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result shown while a scan is still running");

   a_no_result_mid_scan: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> !rsp_valid_ff)
      else $error("result shown between scan steps");

   a_found_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_error == rrs_pkg::ERR_OK || rsp_error == rrs_pkg::ERR_TIMEOUT))
      else $error("found item carries a failure code");

endmodule

// ===== sv/rrs_ram.sv =====
module rrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== test/tb_round_robin_slot_scheduler_unit.sv =====
module tb_round_robin_slot_scheduler_unit;

   localparam int SLOTS = rrs_pkg::SLOTS_DEFAULT;
   localparam int PHASES = 5;
   localparam int PHASE_ITEMS = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  slot;
      logic [63:0] now;
      logic [1:0]  new_status;
      logic [63:0] wake_time;
      logic [3:0]  target_slot;
      logic        target_valid;
      logic [31:0] exit_value;
   } sched_req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  chosen_slot;
      logic [1:0]  wake_reason;
      logic [31:0] returned_code;
      logic [2:0]  error;
      logic [63:0] slice_end;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_func = '0;
   logic [3:0] req_slot = '0;
   logic [63:0] req_now = '0;
   logic [1:0] req_new_status = '0;
   logic [63:0] req_wake_time = '0;
   logic [3:0] req_target_slot = '0;
   logic req_target_valid = 1'b0;
   logic signed [31:0] req_exit_value = '0;
   logic rsp_valid;
   logic rsp_found;
   logic [3:0] rsp_chosen_slot;
   logic [1:0] rsp_wake_reason;
   logic signed [31:0] rsp_returned_code;
   logic [2:0] rsp_error;
   logic [63:0] rsp_slice_end;
   logic csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;

   rrs_pkg::entry_type task_table [SLOTS];
   int current_slot;
   int claim_pointer;
   logic [31:0] slice_setting;

   sched_req_type request_queue [$];
   sched_rsp_type expected_outcomes [$];
   sched_req_type driven_item;
   logic [63:0] clock_now = '0;
   int sender_idle_pct = 0;
   int failures = 0;
   int results_checked = 0;
   int cycle_count = 0;
   int items_by_func [4] = '{0, 0, 0, 0};
   int picked_by_reason [4] = '{0, 0, 0, 0};
   int select_pending = 0;
   int select_deadlock = 0;
   int claim_full = 0;

   round_robin_slot_scheduler_unit #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_slot(req_slot),
      .req_now(req_now),
      .req_new_status(req_new_status),
      .req_wake_time(req_wake_time),
      .req_target_slot(req_target_slot),
      .req_target_valid(req_target_valid),
      .req_exit_value(req_exit_value),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_chosen_slot(rsp_chosen_slot),
      .rsp_wake_reason(rsp_wake_reason),
      .rsp_returned_code(rsp_returned_code),
      .rsp_error(rsp_error),
      .rsp_slice_end(rsp_slice_end),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic sched_rsp_type schedule_item(sched_req_type r);
      sched_rsp_type res;
      rrs_pkg::entry_type e;
      logic pending;
      logic done;
      logic take;
      logic [1:0] reason;
      logic [31:0] code;
      logic [2:0] err;
      int idx;
      int n;
      res = '0;
      case (r.func)
         rrs_pkg::FUNC_SELECT: begin
            pending = 1'b0;
            done = 1'b0;
            idx = current_slot;
            for (n = 0; n < SLOTS && !done; n++) begin
               idx = (idx + 1) % SLOTS;
               e = task_table[idx];
               take = 1'b0;
               reason = rrs_pkg::REASON_READY;
               code = '0;
               err = rrs_pkg::ERR_OK;
               case (e.status)
                  rrs_pkg::STAT_READY: begin
                     take = 1'b1;
                  end
                  rrs_pkg::STAT_SLEEP: begin
                     if (e.wake_time < r.now) begin
                        take = 1'b1;
                        reason = rrs_pkg::REASON_SLEPT;
                     end else begin
                        pending = 1'b1;
                     end
                  end
                  rrs_pkg::STAT_WAIT: begin
                     if (e.target_valid &&
                         task_table[e.target].status == rrs_pkg::STAT_DEAD) begin
                        take = 1'b1;
                        reason = rrs_pkg::REASON_EXITED;
                        code = task_table[e.target].ret_code;
                     end else if (e.wake_time != 0) begin
                        if (e.wake_time < r.now) begin
                           take = 1'b1;
                           reason = rrs_pkg::REASON_TIMEOUT;
                           err = rrs_pkg::ERR_TIMEOUT;
                        end else begin
                           pending = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (take) begin
                  task_table[idx].status = rrs_pkg::STAT_READY;
                  current_slot = idx;
                  res.found = 1'b1;
                  res.chosen_slot = idx[3:0];
                  res.wake_reason = reason;
                  res.returned_code = code;
                  res.error = err;
                  res.slice_end = r.now + {32'd0, slice_setting};
                  done = 1'b1;
               end
            end
            if (!done) begin
               res.error = pending ? rrs_pkg::ERR_PENDING : rrs_pkg::ERR_DEADLOCK;
            end
         end
         rrs_pkg::FUNC_WRITE: begin
            task_table[r.slot].status = r.new_status;
            task_table[r.slot].wake_time = r.wake_time;
            task_table[r.slot].target = r.target_slot;
            task_table[r.slot].target_valid = r.target_valid;
            task_table[r.slot].ret_code = r.exit_value;
         end
         rrs_pkg::FUNC_CLAIM: begin
            done = 1'b0;
            idx = claim_pointer;
            for (n = 0; n < SLOTS && !done; n++) begin
               if (task_table[idx].status == rrs_pkg::STAT_DEAD) begin
                  task_table[idx].status = rrs_pkg::STAT_READY;
                  task_table[idx].wake_time = '0;
                  claim_pointer = (idx + 1) % SLOTS;
                  res.found = 1'b1;
                  res.chosen_slot = idx[3:0];
                  done = 1'b1;
               end else begin
                  idx = (idx + 1) % SLOTS;
               end
            end
            if (!done) begin
               res.error = rrs_pkg::ERR_FULL;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic sched_req_type make_req(logic [1:0] func, logic [3:0] slot,
                                              logic [63:0] now, logic [1:0] status,
                                              logic [63:0] wake, logic [3:0] target,
                                              logic target_valid, logic [31:0] exit_value);
      sched_req_type r;
      r.func = func;
      r.slot = slot;
      r.now = now;
      r.new_status = status;
      r.wake_time = wake;
      r.target_slot = target;
      r.target_valid = target_valid;
      r.exit_value = exit_value;
      return r;
   endfunction

   function automatic sched_req_type random_write();
      sched_req_type r;
      int pick;
      r.func = rrs_pkg::FUNC_WRITE;
      r.slot = 4'($urandom_range(SLOTS - 1));
      r.now = {$urandom, $urandom};
      pick = $urandom_range(99);
      r.new_status = pick < 35 ? rrs_pkg::STAT_DEAD : pick < 50 ? rrs_pkg::STAT_READY :
                     pick < 75 ? rrs_pkg::STAT_SLEEP : rrs_pkg::STAT_WAIT;
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.wake_time = '0;
      end else if (pick < 25) begin
         r.wake_time = {$urandom, $urandom};
      end else begin
         r.wake_time = clock_now + 64'($urandom_range(170)) - 64'd20;
      end
      r.target_slot = 4'($urandom_range(SLOTS - 1));
      r.target_valid = 1'($urandom_range(1));
      r.exit_value = $urandom;
      return r;
   endfunction

   function automatic sched_req_type random_request();
      sched_req_type r;
      int pick;
      r = random_write();
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.func = rrs_pkg::FUNC_SELECT;
         clock_now = clock_now + 64'($urandom_range(12));
         r.now = ($urandom_range(19) == 0) ? {$urandom, $urandom} : clock_now;
      end else if (pick < 96 && pick >= 82) begin
         r.func = rrs_pkg::FUNC_CLAIM;
      end else if (pick >= 96) begin
         r.func = FUNC_UNUSED;
      end
      return r;
   endfunction

   task automatic queue_phase(int count);
      sched_req_type r;
      int queued;
      int j;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(99) < 3) begin
            for (j = 0; j < SLOTS; j++) begin
               r = random_write();
               r.slot = 4'(j);
               request_queue.push_back(r);
            end
            queued += SLOTS;
         end else begin
            request_queue.push_back(random_request());
            queued++;
         end
      end
   endtask

   task automatic wait_drained();
      while (request_queue.size() != 0 || expected_outcomes.size() != 0 || start || busy) begin
         @(posedge clock);
      end
   endtask

   task automatic set_time_slice(logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      slice_setting = value;
   endtask

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= 10) begin
            $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                     field, results_checked, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles without finishing.", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      sched_rsp_type outcome;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            outcome = schedule_item(driven_item);
            expected_outcomes.push_back(outcome);
            items_by_func[driven_item.func]++;
            if (driven_item.func == rrs_pkg::FUNC_SELECT) begin
               if (outcome.found) begin
                  picked_by_reason[outcome.wake_reason]++;
               end else if (outcome.error == rrs_pkg::ERR_PENDING) begin
                  select_pending++;
               end else begin
                  select_deadlock++;
               end
            end else if (driven_item.func == rrs_pkg::FUNC_CLAIM && !outcome.found) begin
               claim_full++;
            end
         end
         if (!(start && busy)) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               driven_item = request_queue.pop_front();
               start <= 1'b1;
               req_func <= driven_item.func;
               req_slot <= driven_item.slot;
               req_now <= driven_item.now;
               req_new_status <= driven_item.new_status;
               req_wake_time <= driven_item.wake_time;
               req_target_slot <= driven_item.target_slot;
               req_target_valid <= driven_item.target_valid;
               req_exit_value <= driven_item.exit_value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      sched_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("Result with no item outstanding: slot %0d, error %0d",
                        rsp_chosen_slot, rsp_error);
            end
         end else begin
            want = expected_outcomes.pop_front();
            check_field("found", 64'(want.found), 64'(rsp_found));
            check_field("chosen_slot", 64'(want.chosen_slot), 64'(rsp_chosen_slot));
            check_field("wake_reason", 64'(want.wake_reason), 64'(rsp_wake_reason));
            check_field("returned_code", 64'(want.returned_code),
                        64'(rsp_returned_code[31:0]));
            check_field("error", 64'(want.error), 64'(rsp_error));
            check_field("slice_end", want.slice_end, rsp_slice_end);
            results_checked++;
         end
      end
   end

   initial begin
      logic [31:0] slice_plan [PHASES];
      int idle_plan [PHASES];
      int phase;
      int i;
      for (i = 0; i < SLOTS; i++) begin
         task_table[i] = '0;
      end
      current_slot = SLOTS - 1;
      claim_pointer = 0;
      slice_setting = rrs_pkg::TIME_SLICE_RESET;
      slice_plan = '{32'd1, 32'hFFFF_FFFF, 32'd0, $urandom_range(5000, 2),
                     rrs_pkg::TIME_SLICE_RESET};
      idle_plan = '{0, 50, 27, 50, 0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, 0, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_CLAIM, 0, 0, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_CLAIM, 0, 0, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, 5, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_WRITE, 0, 0, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 32'h8000_0000));
      request_queue.push_back(make_req(rrs_pkg::FUNC_WRITE, 1, 0, rrs_pkg::STAT_WAIT,
                                       0, 0, 1, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, 10, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_WRITE, 1, 0, rrs_pkg::STAT_SLEEP,
                                       100, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, 100, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, 101, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_WRITE, 1, 0, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_WRITE, 3, 0, rrs_pkg::STAT_WAIT,
                                       200, 3, 1, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, 150, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, 201, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_WRITE, 3, 0, rrs_pkg::STAT_WAIT,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, 300, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_WRITE, 15, '1, rrs_pkg::STAT_WAIT,
                                       '1, 15, 1, 32'h7FFF_FFFF));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, '1, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_WRITE, 5, 0, rrs_pkg::STAT_SLEEP,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(rrs_pkg::FUNC_SELECT, 0, '1, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      request_queue.push_back(make_req(FUNC_UNUSED, 15, '1, rrs_pkg::STAT_WAIT,
                                       '1, 15, 1, 32'hFFFF_FFFF));
      request_queue.push_back(make_req(rrs_pkg::FUNC_CLAIM, 0, 0, rrs_pkg::STAT_DEAD,
                                       0, 0, 0, 0));
      wait_drained();

      for (phase = 0; phase < PHASES; phase++) begin
         set_time_slice(slice_plan[phase]);
         sender_idle_pct = idle_plan[phase];
         case (phase)
            1: clock_now = {$urandom, $urandom};
            3: clock_now = 64'hFFFF_FFFF_FFFF_FC00;
            default: clock_now = 64'($urandom_range(1000));
         endcase
         queue_phase(PHASE_ITEMS);
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         failures += expected_outcomes.size();
         $display("%0d expected results never arrived.", expected_outcomes.size());
      end
      $display("Checked %0d results: %0d selects, %0d writes, %0d claims, %0d unused codes,",
               results_checked, items_by_func[rrs_pkg::FUNC_SELECT],
               items_by_func[rrs_pkg::FUNC_WRITE], items_by_func[rrs_pkg::FUNC_CLAIM],
               items_by_func[FUNC_UNUSED]);
      $display("%0d ready, %0d woken, %0d exited, %0d timed out, %0d pending,",
               picked_by_reason[rrs_pkg::REASON_READY],
               picked_by_reason[rrs_pkg::REASON_SLEPT],
               picked_by_reason[rrs_pkg::REASON_EXITED],
               picked_by_reason[rrs_pkg::REASON_TIMEOUT], select_pending);
      $display("%0d deadlocked and %0d full tables seen.", select_deadlock, claim_full);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
